// ===== hdl/pec_pkg.sv =====
// Package for the polygon edge crossing checker.
// Holds the request and result types, the command codes, the controller states
// and the arithmetic helpers. It has no dependencies.
package pec_pkg;

	// Coordinate and arithmetic widths follow from the 16-bit coordinate fields.
	localparam int CoordW     = 16;
	localparam int DiffW      = CoordW + 1;
	localparam int ProdW      = 2 * DiffW;
	localparam int EdgeTotalW = 9;
	localparam int MaxEdgesDef = 256;

	typedef enum logic [1:0] {
		CMD_CLEAR       = 2'd0,
		CMD_APPEND      = 2'd1,
		CMD_TEST_SEG    = 2'd2,
		CMD_TEST_INSERT = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                     command;
		logic signed [CoordW-1:0] start_x;
		logic signed [CoordW-1:0] start_y;
		logic signed [CoordW-1:0] end_x;
		logic signed [CoordW-1:0] end_y;
		logic signed [CoordW-1:0] point_x;
		logic signed [CoordW-1:0] point_y;
	} item_t;

	typedef struct packed {
		logic                  crossing_found;
		logic                  insert_ok;
		logic [EdgeTotalW-1:0] edge_total;
		logic                  status;
	} result_t;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
	} vtx_t;

	typedef struct packed {
		vtx_t s;
		vtx_t e;
	} edge_t;

	// The four differences of one orientation test.
	typedef struct packed {
		logic signed [DiffW-1:0] p;
		logic signed [DiffW-1:0] q;
		logic signed [DiffW-1:0] r;
		logic signed [DiffW-1:0] s;
	} diff4_t;

	// The two products of one orientation test.
	typedef struct packed {
		logic signed [ProdW-1:0] lhs;
		logic signed [ProdW-1:0] rhs;
	} prod2_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic clr_count;
		logic append;
		logic scan_rst;
		logic scan_issue;
		logic pass_b;
		logic load_out;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t command;
		logic count_zero;
		logic scan_last;
		logic pipe_busy;
		logic out_free;
	} dp_status_t;

	// Exact difference of two coordinates, one bit wider than its operands.
	function automatic logic signed [DiffW-1:0] sub_c(
		logic signed [CoordW-1:0] a,
		logic signed [CoordW-1:0] b
	);
		return {a[CoordW-1], a} - {b[CoordW-1], b};
	endfunction

	// Differences for the test (c.y-a.y)*(b.x-a.x) > (b.y-a.y)*(c.x-a.x).
	function automatic diff4_t ccw_diffs(vtx_t a, vtx_t b, vtx_t c);
		diff4_t d;
		d.p = sub_c(c.y, a.y);
		d.q = sub_c(b.x, a.x);
		d.r = sub_c(b.y, a.y);
		d.s = sub_c(c.x, a.x);
		return d;
	endfunction

	function automatic logic same_vtx(vtx_t a, vtx_t b);
		return (a.x == b.x) && (a.y == b.y);
	endfunction

endpackage

// ===== hdl/pec_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module pec_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/pec_ctrl.sv =====
// Controller state machine of the polygon edge crossing checker.
// Depends on pec_pkg for the state, command and status types.
module pec_ctrl import pec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  dp_status_t dp_status,
	output ctrl_cmd_t  ctrl_cmd
);

	state_t state_q, state_d;
	logic   pass_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (dp_status.command inside {CMD_TEST_SEG, CMD_TEST_INSERT} &&
				    !dp_status.count_zero) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_SCAN: begin
				if (dp_status.scan_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!dp_status.pipe_busy) begin
					if (dp_status.command == CMD_TEST_INSERT && !pass_q) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_RESULT;
					end
				end
			end
			ST_RESULT: begin
				if (dp_status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		ctrl_cmd        = '0;
		ctrl_cmd.pass_b = pass_q;
		item_stall      = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall       = 1'b0;
				ctrl_cmd.capture = item_valid;
			end
			ST_EXEC: begin
				ctrl_cmd.clr_count = (dp_status.command == CMD_CLEAR);
				ctrl_cmd.append    = (dp_status.command == CMD_APPEND);
				ctrl_cmd.scan_rst  = 1'b1;
			end
			ST_SCAN: begin
				ctrl_cmd.scan_issue = 1'b1;
			end
			ST_DRAIN: begin
				ctrl_cmd.scan_rst = 1'b1;
			end
			ST_RESULT: begin
				ctrl_cmd.load_out = dp_status.out_free;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	// State and pass registers; the second pass serves the insertion test.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				pass_q <= 1'b0;
			end else if (state_q == ST_DRAIN && state_d == ST_SCAN) begin
				pass_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hdl/pec_dp.sv =====
// Datapath of the polygon edge crossing checker: edge memory, counters,
// orientation pipeline and result register. Depends on pec_pkg and pec_ram.
module pec_dp import pec_pkg::*; #(
	parameter int MAX_EDGES = MaxEdgesDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	output result_t    result,
	output logic       result_valid,
	input  logic       result_stall,
	input  ctrl_cmd_t  ctrl_cmd,
	output dp_status_t dp_status
);

	localparam int IdxW = $clog2(MAX_EDGES);
	localparam int CntW = $clog2(MAX_EDGES + 1);

	item_t           item_q;
	logic [CntW-1:0] count_q;
	logic [IdxW-1:0] idx_q;
	logic            hit_q;
	logic            refused_q;
	logic            full;
	edge_t           rd_edge;
	logic [$bits(edge_t)-1:0] rdata;
	edge_t           wr_edge;
	vtx_t            seg_s, seg_e;

	logic   valid_s1, valid_s2, valid_s3;
	logic   skip_s2, skip_s3;
	diff4_t diff_s2 [4];
	prod2_t prod_s3 [4];
	logic   ccw [4];
	logic   cross_now;

	result_t result_q;
	logic    result_valid_q;

	assign full = (count_q == CntW'(MAX_EDGES));

	assign wr_edge.s.x = item_q.start_x;
	assign wr_edge.s.y = item_q.start_y;
	assign wr_edge.e.x = item_q.end_x;
	assign wr_edge.e.y = item_q.end_y;

	pec_ram #(
		.WIDTH($bits(edge_t)),
		.DEPTH(MAX_EDGES)
	) u_edge_ram (
		.clk  (clk),
		.we   (ctrl_cmd.append && !full),
		.waddr(count_q[IdxW-1:0]),
		.wdata(wr_edge),
		.re   (ctrl_cmd.scan_issue),
		.raddr(idx_q),
		.rdata(rdata)
	);

	assign rd_edge = edge_t'(rdata);

	// Request capture.
	always_ff @(posedge clk) begin
		if (ctrl_cmd.capture) begin
			item_q <= item;
		end
	end

	// Edge count, scan index, refusal flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			idx_q     <= '0;
			refused_q <= 1'b0;
		end else begin
			if (ctrl_cmd.clr_count) begin
				count_q <= '0;
			end else if (ctrl_cmd.append && !full) begin
				count_q <= count_q + 1'b1;
			end
			if (ctrl_cmd.capture) begin
				refused_q <= 1'b0;
			end else if (ctrl_cmd.append && full) begin
				refused_q <= 1'b1;
			end
			if (ctrl_cmd.scan_rst) begin
				idx_q <= '0;
			end else if (ctrl_cmd.scan_issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// The tested segment: the whole segment, or one half of an insertion.
	always_comb begin
		seg_s.x = item_q.start_x;
		seg_s.y = item_q.start_y;
		seg_e.x = item_q.end_x;
		seg_e.y = item_q.end_y;
		if (item_q.command == CMD_TEST_INSERT) begin
			if (ctrl_cmd.pass_b) begin
				seg_s.x = item_q.point_x;
				seg_s.y = item_q.point_y;
			end else begin
				seg_e.x = item_q.point_x;
				seg_e.y = item_q.point_y;
			end
		end
	end

	// Pipeline valid bits: read, differences, products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= ctrl_cmd.scan_issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage two: shared-endpoint check and the differences of four tests.
	always_ff @(posedge clk) begin
		skip_s2 <= same_vtx(rd_edge.s, seg_s) || same_vtx(rd_edge.s, seg_e) ||
		           same_vtx(rd_edge.e, seg_s) || same_vtx(rd_edge.e, seg_e);
		diff_s2[0] <= ccw_diffs(rd_edge.s, seg_s, seg_e);
		diff_s2[1] <= ccw_diffs(rd_edge.e, seg_s, seg_e);
		diff_s2[2] <= ccw_diffs(rd_edge.s, rd_edge.e, seg_e);
		diff_s2[3] <= ccw_diffs(rd_edge.s, rd_edge.e, seg_s);
	end

	// Stage three: one pair of exact products per orientation test.
	always_ff @(posedge clk) begin
		skip_s3 <= skip_s2;
		for (int k = 0; k < 4; k++) begin
			prod_s3[k].lhs <= diff_s2[k].p * diff_s2[k].q;
			prod_s3[k].rhs <= diff_s2[k].r * diff_s2[k].s;
		end
	end

	// Strict orientation compare and crossing decision.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ccw[k] = (prod_s3[k].lhs > prod_s3[k].rhs);
		end
		cross_now = valid_s3 && !skip_s3 && (ccw[0] != ccw[1]) && (ccw[2] != ccw[3]);
	end

	// Crossing accumulator over both passes.
	always_ff @(posedge clk) begin
		if (ctrl_cmd.capture) begin
			hit_q <= 1'b0;
		end else if (cross_now) begin
			hit_q <= 1'b1;
		end
	end

	// Result register; a new result may load as the old one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctrl_cmd.load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_cmd.load_out) begin
			result_q.crossing_found <= hit_q;
			result_q.insert_ok      <= (item_q.command == CMD_TEST_INSERT) && !hit_q;
			result_q.edge_total     <= EdgeTotalW'(count_q);
			result_q.status         <= refused_q;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	// Status towards the controller.
	assign dp_status.command    = item_q.command;
	assign dp_status.count_zero = (count_q == '0);
	assign dp_status.scan_last  = ({1'b0, idx_q} == (IdxW+1)'(count_q - 1'b1));
	assign dp_status.pipe_busy  = valid_s1 || valid_s2 || valid_s3;
	assign dp_status.out_free   = !result_valid_q || !result_stall;

endmodule

// ===== hdl/polygon_edge_crossing_checker.sv =====
// Top level of the polygon edge crossing checker.
// Depends on pec_pkg, pec_ctrl, pec_dp and pec_ram.
//
// The block holds up to MAX_EDGES polygon edges in a memory with one write
// port and one registered read port, and takes one request at a time. Clear
// and append requests pass from acceptance through the execute and result
// states back to idle. A segment test reads one stored edge per cycle
// through a three-stage orientation pipeline; an insertion test walks the
// store twice. A finished result waits in an output register, and the next
// request is taken while it waits.
module polygon_edge_crossing_checker import pec_pkg::*; #(
	parameter int MAX_EDGES = MaxEdgesDef
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    item_valid,
	output logic    item_stall,
	output result_t result,
	output logic    result_valid,
	input  logic    result_stall
);

	ctrl_cmd_t  ctrl_cmd;
	dp_status_t dp_status;

	pec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.dp_status (dp_status),
		.ctrl_cmd  (ctrl_cmd)
	);

	pec_dp #(
		.MAX_EDGES(MAX_EDGES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.ctrl_cmd    (ctrl_cmd),
		.dp_status   (dp_status)
	);

endmodule
